[design/pps_pkg.sv]
// Shared types, constants and helper functions for the programmable priority
// signal select unit. Every other design file uses this package by scoped name.
`default_nettype none

package pps_pkg;

  // Number of signals that can be selected, and the list positions that are walked.
  localparam int NUM_SIGNALS = 64;

  // Bits needed to name one signal, and the power-of-two span of such a name.
  localparam int SIG_IDX_W = (NUM_SIGNALS > 1) ? $clog2(NUM_SIGNALS) : 1;
  localparam int SIG_SPAN  = 1 << SIG_IDX_W;

  // Priority list geometry: eight 64-bit words of eight byte entries each.
  localparam int PRIO_WORDS  = 8;
  localparam int WORD_W      = 64;
  localparam int ENTRY_W     = 8;
  localparam int WORD_BYTES  = WORD_W / ENTRY_W;
  localparam int LIST_LEN    = PRIO_WORDS * WORD_BYTES;
  localparam int LIST_IDX_W  = $clog2(LIST_LEN);
  localparam int WORD_IDX_W  = $clog2(PRIO_WORDS);

  // Field widths of the item and result channels.
  localparam int SET_W    = 64;
  localparam int CHOSEN_W = 7;

  // Configuration port index width; indexes past the last word are ignored.
  localparam int CFG_IDX_W = 8;

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // Whole priority list, entry p in byte p; same bit layout as the stacked words.
  typedef logic [LIST_LEN-1:0][ENTRY_W-1:0] prio_list_t;
  typedef logic [PRIO_WORDS-1:0][WORD_W-1:0] prio_words_t;

  // Per-position match flags carried from the front to the back.
  typedef logic [NUM_SIGNALS-1:0] hit_vec_t;

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // Reset value of one priority word: the identity order.
  function automatic logic [WORD_W-1:0] prio_reset_word(input int w);
    logic [WORD_W-1:0] word;
    word = '0;
    for (int b = 0; b < WORD_BYTES; b++) begin
      word[b*ENTRY_W +: ENTRY_W] = ENTRY_W'(w * WORD_BYTES + b);
    end
    return word;
  endfunction

endpackage

`default_nettype wire

[design/programmable_priority_signal_select_unit.sv]
// Top level of the programmable priority signal select unit: priority list
// registers and the front, queue and back stages. Uses pps_pkg.
//
// Each item carries a pending set and a blocked set; the unit walks a 64-entry
// priority list (eight 64-bit words, lowest byte first) and returns the first
// listed signal that is pending and not blocked, as its number plus one, or 0
// when none is deliverable. Entries of 64 or more are skipped. The unit takes
// one item every clock cycle while in_stall_o is low and returns one result per
// item, in order. An accepted item moves from the front register into the queue,
// and the output register then takes it from the queue. While the output is
// stalled, the front register and the two-entry queue hold up to three items,
// and the input stalls only once all three are occupied. Configuration writes
// are always ready and take effect at once; indexes of 8 and above are ignored.
// After reset the list is the identity order 0 to 63.
`default_nettype none

module programmable_priority_signal_select_unit (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Item channel
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [pps_pkg::SET_W-1:0]         pending_set_i,
  input  wire logic [pps_pkg::SET_W-1:0]         blocked_set_i,
  // Result channel
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [pps_pkg::CHOSEN_W-1:0]           chosen_signal_o,
  // Configuration write channel
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [pps_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [pps_pkg::WORD_W-1:0]        cfg_data_i
);

  pps_pkg::prio_words_t   prio_q;
  pps_pkg::prio_list_t    prio_list;
  pps_pkg::queue_stat_t   q_stat;
  pps_pkg::hit_vec_t      push_hits;
  pps_pkg::hit_vec_t      head_hits;
  logic                   push;
  logic                   pop;
  logic                   cfg_write;

  // Register writes are accepted in every cycle.
  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o &&
                       (cfg_index_i < pps_pkg::CFG_IDX_W'(pps_pkg::PRIO_WORDS));

  // Priority list words.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int w = 0; w < pps_pkg::PRIO_WORDS; w++) begin
        prio_q[w] <= pps_pkg::prio_reset_word(w);
      end
    end else if (cfg_write) begin
      prio_q[cfg_index_i[pps_pkg::WORD_IDX_W-1:0]] <= cfg_data_i;
    end
  end

  // The stacked words already hold entry p in byte p.
  assign prio_list = pps_pkg::prio_list_t'(prio_q);

  pps_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .pending_set_i (pending_set_i),
    .blocked_set_i (blocked_set_i),
    .prio_list_i   (prio_list),
    .q_stat_i      (q_stat),
    .push_o        (push),
    .hits_o        (push_hits)
  );

  pps_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_hits),
    .pop_i       (pop),
    .head_o      (head_hits),
    .stat_o      (q_stat)
  );

  pps_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_i          (head_hits),
    .q_stat_i        (q_stat),
    .prio_list_i     (prio_list),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .chosen_signal_o (chosen_signal_o)
  );

endmodule

`default_nettype wire

[design/pps_front.sv]
// Front stage: registers an accepted item as its deliverable set and classifies
// every list position as matching or not. Uses pps_pkg.
`default_nettype none

module pps_front (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [pps_pkg::SET_W-1:0]      pending_set_i,
  input  wire logic [pps_pkg::SET_W-1:0]      blocked_set_i,
  input  wire pps_pkg::prio_list_t            prio_list_i,
  input  wire pps_pkg::queue_stat_t           q_stat_i,
  output logic                                push_o,
  output pps_pkg::hit_vec_t                   hits_o
);

  logic                           valid_q, valid_d;
  logic [pps_pkg::SIG_SPAN-1:0]   ready_q;
  logic                           accept;
  logic                           advance;

  // The stage moves on into the queue whenever the queue has room.
  assign advance    = valid_q && !q_stat_i.full;
  assign in_stall_o = valid_q && q_stat_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign push_o     = advance;
  assign valid_d    = accept || (valid_q && !advance);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Deliverable signals: pending and not blocked, high bits dropped.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      ready_q <= pps_pkg::SIG_SPAN'(pending_set_i[pps_pkg::NUM_SIGNALS-1:0] &
                                    ~blocked_set_i[pps_pkg::NUM_SIGNALS-1:0]);
    end
  end

  // A position matches when its entry names a real signal that is deliverable.
  always_comb begin
    for (int p = 0; p < pps_pkg::NUM_SIGNALS; p++) begin
      hits_o[p] = (prio_list_i[p] < pps_pkg::ENTRY_W'(pps_pkg::NUM_SIGNALS)) &&
                  ready_q[prio_list_i[p][pps_pkg::SIG_IDX_W-1:0]];
    end
  end

endmodule

`default_nettype wire

[design/pps_queue.sv]
// Short queue of match vectors between the front and the back.
// Uses pps_pkg for the depth and the entry type.
`default_nettype none

module pps_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire pps_pkg::hit_vec_t    push_data_i,
  input  wire logic                 pop_i,
  output pps_pkg::hit_vec_t         head_o,
  output pps_pkg::queue_stat_t      stat_o
);

  pps_pkg::hit_vec_t                  mem_q [pps_pkg::QUEUE_DEPTH];
  logic [pps_pkg::QUEUE_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [pps_pkg::QUEUE_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [pps_pkg::QUEUE_CNT_W-1:0]    count_q, count_d;

  assign stat_o.full  = (count_q == pps_pkg::QUEUE_CNT_W'(pps_pkg::QUEUE_DEPTH));
  assign stat_o.empty = (count_q == '0);
  assign head_o       = mem_q[rd_ptr_q];

  // Pointer wrap and occupancy.
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == pps_pkg::QUEUE_PTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == pps_pkg::QUEUE_PTR_W'(pps_pkg::QUEUE_DEPTH - 1)) ?
                 '0 : rd_ptr_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage is written only at the tail.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

[design/pps_back.sv]
// Back stage: finds the first matching list position, looks up its entry and
// holds the selected signal number in the output register. Uses pps_pkg.
`default_nettype none

module pps_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire pps_pkg::hit_vec_t             head_i,
  input  wire pps_pkg::queue_stat_t          q_stat_i,
  input  wire pps_pkg::prio_list_t           prio_list_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic [pps_pkg::CHOSEN_W-1:0]       chosen_signal_o
);

  logic                               out_valid_q, out_valid_d;
  logic [pps_pkg::CHOSEN_W-1:0]       chosen_q;
  logic [pps_pkg::CHOSEN_W-1:0]       chosen_d;
  logic [pps_pkg::LIST_IDX_W-1:0]     first_pos;
  logic                               found;

  // Take the queue head whenever the output register is free or being drained.
  assign pop_o       = !q_stat_i.empty && (!out_valid_q || !out_stall_i);
  assign out_valid_d = pop_o || (out_valid_q && out_stall_i);

  // Priority encoder: lowest matching position wins.
  always_comb begin
    first_pos = '0;
    found     = 1'b0;
    for (int p = pps_pkg::NUM_SIGNALS - 1; p >= 0; p--) begin
      if (head_i[p]) begin
        first_pos = pps_pkg::LIST_IDX_W'(p);
        found     = 1'b1;
      end
    end
  end

  // Signal number is the winning entry plus one, or zero with no match.
  assign chosen_d = found ?
                    (prio_list_i[first_pos][pps_pkg::CHOSEN_W-1:0] + 1'b1) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      chosen_q <= chosen_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign chosen_signal_o = chosen_q;

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for programmable_priority_signal_select_unit.
// It needs pps_pkg and the unit itself. It predicts each chosen signal from its own copy of
// the priority list and checks every result in order.
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD   = 20;
  localparam int RESET_CYCLES = 8;
  localparam int DRAIN_CYCLES = 6;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int NSIG         = pps_pkg::NUM_SIGNALS;
  localparam int NWORDS       = pps_pkg::PRIO_WORDS;
  localparam int ENT_W        = pps_pkg::ENTRY_W;
  localparam int WRD_W        = pps_pkg::WORD_W;
  localparam int PER_WORD     = pps_pkg::WORD_BYTES;
  localparam int ITEMS_PER_LOAD = 100;

  // Register indexes of the configuration port.
  localparam logic [pps_pkg::CFG_IDX_W-1:0] REG_PRIO_WORD_FIRST = '0;
  localparam logic [pps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_LOW    =
    pps_pkg::CFG_IDX_W'(NWORDS);
  localparam logic [pps_pkg::CFG_IDX_W-1:0] REG_UNMAPPED_HIGH   = '1;

  // Shapes of priority list used by the random traffic.
  typedef enum int {
    LIST_IDENTITY,
    LIST_REVERSED,
    LIST_SHUFFLED,
    LIST_HOLEY,
    LIST_RANDOM_BYTES
  } list_style_e;

  logic                               clk = 1'b0;
  logic                               rst_n;
  logic                               in_valid;
  logic                               in_stall;
  logic [pps_pkg::SET_W-1:0]          pending_set;
  logic [pps_pkg::SET_W-1:0]          blocked_set;
  logic                               out_valid;
  logic                               out_stall;
  logic [pps_pkg::CHOSEN_W-1:0]       chosen_signal;
  logic                               cfg_valid;
  logic                               cfg_ready;
  logic [pps_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [WRD_W-1:0]                   cfg_data;

  // Own copy of the priority list words, and the chosen signals still to come out.
  logic [WRD_W-1:0]                   list_word_m [NWORDS];
  logic [pps_pkg::CHOSEN_W-1:0]       chosen_q [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int items_accepted = 0;
  int results_checked = 0;
  int list_loads     = 0;

  programmable_priority_signal_select_unit dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .pending_set_i   (pending_set),
    .blocked_set_i   (blocked_set),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .chosen_signal_o (chosen_signal),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .cfg_index_i     (cfg_index),
    .cfg_data_i      (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Walk the list in order and return the first ready signal number, or 0 if none.
  function automatic logic [pps_pkg::CHOSEN_W-1:0] first_ready_signal(
    input logic [pps_pkg::SET_W-1:0] pend,
    input logic [pps_pkg::SET_W-1:0] blk
  );
    logic [pps_pkg::SET_W-1:0] ready;
    logic [ENT_W-1:0]          entry;
    ready = pend & ~blk;
    for (int pos = 0; pos < NSIG; pos++) begin
      entry = list_word_m[pos / PER_WORD][(pos % PER_WORD) * ENT_W +: ENT_W];
      if (entry < NSIG && ready[entry[5:0]]) begin
        return pps_pkg::CHOSEN_W'(entry + 1);
      end
    end
    return '0;
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Build a priority list of the requested shape.
  function automatic pps_pkg::prio_list_t make_list(input list_style_e style);
    pps_pkg::prio_list_t lst;
    logic [ENT_W-1:0]    tmp;
    int                  j;
    for (int p = 0; p < pps_pkg::LIST_LEN; p++) begin
      lst[p] = ENT_W'(p);
    end
    case (style)
      LIST_REVERSED: begin
        for (int p = 0; p < pps_pkg::LIST_LEN; p++) lst[p] = ENT_W'(NSIG - 1 - p);
      end
      LIST_SHUFFLED, LIST_HOLEY: begin
        for (int p = pps_pkg::LIST_LEN - 1; p > 0; p--) begin
          j = $urandom_range(p);
          tmp = lst[p];
          lst[p] = lst[j];
          lst[j] = tmp;
        end
        // Punch holes: out-of-range entries and repeated signals.
        if (style == LIST_HOLEY) begin
          for (int p = 0; p < pps_pkg::LIST_LEN; p++) begin
            if ($urandom_range(3) == 0) begin
              lst[p] = $urandom_range(1) ? ENT_W'($urandom_range(255, NSIG))
                                         : ENT_W'($urandom_range(NSIG - 1));
            end
          end
        end
      end
      LIST_RANDOM_BYTES: begin
        for (int p = 0; p < pps_pkg::LIST_LEN; p++) lst[p] = ENT_W'($urandom_range(255));
      end
      default: begin
      end
    endcase
    return lst;
  endfunction

  // Track accepted items and configuration writes, and check each result.
  always @(posedge clk) begin
    logic [pps_pkg::CHOSEN_W-1:0] want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready && cfg_index < NWORDS) begin
        list_word_m[cfg_index[2:0]] = cfg_data;
      end
      if (in_valid && !in_stall) begin
        chosen_q.push_back(first_ready_signal(pending_set, blocked_set));
        items_accepted++;
      end
      if (out_valid && !out_stall) begin
        if (chosen_q.size() == 0) begin
          $display("%0t: result with no item waiting: expected none, actual chosen_signal=%0d",
                   $time, chosen_signal);
          error_count++;
        end else begin
          want = chosen_q.pop_front();
          results_checked++;
          if (chosen_signal !== want) begin
            $display("%0t: chosen_signal mismatch: expected %0d, actual %0d",
                     $time, want, chosen_signal);
            error_count++;
          end
        end
      end
    end
  end

  // Receiver stalls at random at the configured rate.
  always @(negedge clk) begin
    out_stall = ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one item, idling first at the configured rate, and wait until it is taken.
  task automatic send_item(input logic [63:0] pend, input logic [63:0] blk);
    forever begin
      @(negedge clk);
      if ($urandom_range(99) < send_idle_pct) begin
        in_valid = 1'b0;
      end else begin
        break;
      end
    end
    in_valid    = 1'b1;
    pending_set = pend;
    blocked_set = blk;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait until every result has come out.
  task automatic quiesce();
    @(negedge clk);
    in_valid = 1'b0;
    while (chosen_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_prio_reg(input logic [pps_pkg::CFG_IDX_W-1:0] index,
                                input logic [WRD_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = index;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Load a whole priority list once the unit is idle.
  task automatic load_list(input pps_pkg::prio_list_t lst);
    logic [pps_pkg::LIST_LEN*ENT_W-1:0] flat;
    flat = lst;
    quiesce();
    for (int w = 0; w < NWORDS; w++) begin
      write_prio_reg(REG_PRIO_WORD_FIRST + pps_pkg::CFG_IDX_W'(w),
                     flat[w * WRD_W +: WRD_W]);
    end
    list_loads++;
  endtask

  // Random item with a mix of densities so the winner lands all over the list.
  task automatic send_random_item();
    logic [63:0] pend;
    logic [63:0] blk;
    int          k;
    k = $urandom_range(NSIG - 1);
    case ($urandom_range(9))
      0, 1, 2: begin
        pend = rand64();
        blk  = rand64();
      end
      3, 4: begin
        pend = (64'd1 << k) | (64'd1 << $urandom_range(NSIG - 1));
        blk  = rand64() & rand64();
      end
      5, 6: begin
        pend = rand64() | (64'd1 << k);
        blk  = ~(64'd1 << k);
      end
      7: begin
        pend = rand64() | rand64();
        blk  = rand64() | rand64();
      end
      8: begin
        pend = $urandom_range(1) ? '1 : '0;
        blk  = $urandom_range(1) ? '1 : rand64() & rand64() & rand64();
      end
      default: begin
        pend = rand64() & rand64() & rand64();
        blk  = '0;
      end
    endcase
    send_item(pend, blk);
  endtask

  // Field extremes under the identity order left by reset.
  task automatic test_identity_order();
    send_item('0, '0);
    send_item('1, '0);
    send_item('1, '1);
    send_item('0, '1);
    send_item(64'd1 << 63, '0);
    send_item('1, ~(64'd1 << 63));
    send_item(64'd1, '0);
    send_item(64'd1 << 31, '0);
    send_item(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    send_item(64'h5555_5555_5555_5555, 64'h5555_5555_5555_5555);
  endtask

  // Extreme lists: all zero, all out of range, reversed, and one with holes and repeats.
  task automatic test_list_extremes();
    pps_pkg::prio_list_t lst;
    load_list('0);
    send_item('1, '0);
    send_item(~64'd1, '0);
    load_list('1);
    send_item('1, '0);
    load_list(make_list(LIST_REVERSED));
    send_item('1, '0);
    send_item(64'd1, '0);
    // Front half out of range, then a run of one repeated signal, then signals 0 to 15.
    for (int p = 0; p < pps_pkg::LIST_LEN; p++) begin
      if (p < 32) lst[p] = (p % 2 == 0) ? ENT_W'(8'hC0 + p) : ENT_W'(NSIG + p);
      else if (p < 48) lst[p] = ENT_W'(7);
      else lst[p] = ENT_W'(p - 48);
    end
    load_list(lst);
    send_item('1, '0);
    send_item('1, 64'd1 << 7);
    send_item(64'd1 << 15, '0);
    send_item(64'd1 << 40, '0);
  endtask

  // Writes past the last list word must leave the list alone.
  task automatic test_unmapped_index();
    quiesce();
    write_prio_reg(REG_UNMAPPED_LOW, '0);
    write_prio_reg(REG_UNMAPPED_HIGH, '1);
    send_item('1, '0);
    send_item('1, 64'd1 << 7);
    send_item(64'd1 << 3, '0);
  endtask

  // Random lists and items under each mix of sender idling and receiver stalls.
  task automatic test_random_traffic();
    int idle_mix [4]  = '{0, 70, 0, 10};
    int stall_mix [4] = '{0, 0, 70, 10};
    for (int m = 0; m < 4; m++) begin
      for (int c = 0; c < 3; c++) begin
        load_list(make_list(list_style_e'($urandom_range(LIST_RANDOM_BYTES))));
        send_idle_pct  = idle_mix[m];
        recv_stall_pct = stall_mix[m];
        repeat (ITEMS_PER_LOAD) send_random_item();
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  initial begin
    // Own copy of the identity order that reset establishes.
    for (int w = 0; w < NWORDS; w++) begin
      for (int b = 0; b < PER_WORD; b++) begin
        list_word_m[w][b * ENT_W +: ENT_W] = ENT_W'(w * PER_WORD + b);
      end
    end
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    pending_set = '0;
    blocked_set = '0;
    out_stall   = 1'b0;
    cfg_valid   = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_identity_order();
    test_list_extremes();
    test_unmapped_index();
    test_random_traffic();
    quiesce();

    $display("Checked %0d results for %0d items over %0d priority list loads,",
             results_checked, items_accepted, list_loads);
    $display("with idle and stall mixes of none, sender, receiver and both.");
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("Timeout with %0d results still outstanding.", chosen_q.size());
    $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
